// ===== hdl/msmix_pkg.sv =====
// ============================================================================
// msmix_pkg
// Shared types and constants for the multichannel sample mixer: command
// codes, controller states, stream payload layout and default sizes.
// ============================================================================
package msmix_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_VOICES        = 16;
  localparam int DEF_SAMPLE_FRAMES = 65536;
  localparam int DEF_MAX_SOUNDS    = 64;

  // Command codes carried in tuser
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_FRAME = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_SOUND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PLAY        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP        = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd5;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = 16;
  localparam int LEN_W    = 17;
  localparam int SEL_W    = 6;
  localparam int VOL_W    = 16;
  localparam int VSEL_W   = 4;
  localparam int REPLY_W  = 6;
  localparam int GAIN_W   = 16;

  // Gain and rounding constants (Q1.15)
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;
  localparam logic [15:0]       ROUND_HALF = 16'd16384;
  localparam int                FRAC_BITS  = 15;

  // Input tdata layout, lowest bit first
  localparam int IN_TDATA_W  = 112;
  localparam int IN_FADDR_LO = 0;
  localparam int IN_LEFT_LO  = 16;
  localparam int IN_RIGHT_LO = 32;
  localparam int IN_START_LO = 48;
  localparam int IN_LEN_LO   = 64;
  localparam int IN_SEL_LO   = 81;
  localparam int IN_VOL_LO   = 87;
  localparam int IN_LOOP_BIT = 103;
  localparam int IN_VSEL_LO  = 104;

  // Output tdata layout, lowest bit first
  localparam int OUT_TDATA_W    = 40;
  localparam int OUT_STATUS_BIT = 32;
  localparam int OUT_REPLY_LO   = 33;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PLAY,
    ST_TICK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

// ===== hdl/multichannel_sample_mixer.sv =====
// ============================================================================
// multichannel_sample_mixer
// Stereo sample-playback mixer with VOICES voices. Each command transaction
// gives exactly one result transaction. A tick walks the voices through a
// pipeline at one voice per cycle (voice memory read, sound table read,
// sample memory read, gain, multiply, accumulate) and gives its result once
// the pipeline has drained. Play scans the active flags one voice per cycle
// and stops at the first free voice or at the last voice. A new command is
// taken while the previous result still waits in the output register.
// SAMPLE_FRAMES must be a power of two: frame addresses wrap by masking.
// master_gain may only be written while no command is in flight.
// ============================================================================
module multichannel_sample_mixer
  import msmix_pkg::*;
#(
  parameter int VOICES        = DEF_VOICES,
  parameter int SAMPLE_FRAMES = DEF_SAMPLE_FRAMES,
  parameter int MAX_SOUNDS    = DEF_MAX_SOUNDS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // frame_address[15:0], sample_left[31:16], sample_right[47:32],
  // sound_start[63:48], sound_length[80:64], sound_select[86:81],
  // voice_volume[102:87], loop_enable[103], voice_select[107:104], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[2:0]
  input  logic [CMD_W-1:0]       s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_left[15:0], out_right[31:16], status[32], reply_index[38:33], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Master gain register
  input  logic                   gain_wr_en,
  input  logic [GAIN_W-1:0]      gain_wr_data
);

  localparam int VAW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SAW  = (MAX_SOUNDS > 1) ? $clog2(MAX_SOUNDS) : 1;
  localparam int SCW  = $clog2(MAX_SOUNDS + 1);
  localparam int AW   = $clog2(SAMPLE_FRAMES);
  localparam int SUMW = (AW > LEN_W + 1) ? AW : LEN_W + 1;
  localparam int PW   = 2 * SAMPLE_W + 1;
  localparam int ACCW = PW + VAW + 1;
  localparam int TW   = ACCW + 1;
  localparam logic signed [TW-1:0] Q_MAX = TW'(32767);
  localparam logic signed [TW-1:0] Q_MIN = TW'(-32768);

  typedef struct packed {
    logic [SAW-1:0]   snd;
    logic [LEN_W-1:0] pos;
    logic [VOL_W-1:0] vol;
    logic             loop_en;
  } voice_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
  } sound_t;

  // Round once at bit 15 and saturate to a 16-bit sample
  function automatic logic [SAMPLE_W-1:0] round_clip(input logic signed [ACCW-1:0] a);
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] q;
    t = TW'(a) + TW'(ROUND_HALF);
    q = t >>> FRAC_BITS;
    if (q > Q_MAX) begin
      return SAMPLE_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      return SAMPLE_W'(Q_MIN);
    end else begin
      return SAMPLE_W'(q);
    end
  endfunction

  // Controller and captured command
  state_t state, state_next;
  logic [CMD_W-1:0]    item_cmd;
  logic [ADDR_W-1:0]   item_frame_address;
  logic [SAMPLE_W-1:0] item_sample_left;
  logic [SAMPLE_W-1:0] item_sample_right;
  logic [ADDR_W-1:0]   item_sound_start;
  logic [LEN_W-1:0]    item_sound_length;
  logic [SEL_W-1:0]    item_sound_select;
  logic [VOL_W-1:0]    item_voice_volume;
  logic                item_loop_enable;
  logic [VSEL_W-1:0]   item_voice_select;

  logic [GAIN_W-1:0]   master_gain;
  logic [SCW-1:0]      sound_count;
  logic [VOICES-1:0]   active;
  logic [VAW-1:0]      idx;
  logic                idx_last;
  logic                snd_ok;
  logic                stop_ok;
  logic                add_bad;
  logic                out_free;
  logic                pipe_busy;

  // Result holding registers
  logic [SAMPLE_W-1:0] res_left;
  logic [SAMPLE_W-1:0] res_right;
  logic                res_status;
  logic [REPLY_W-1:0]  res_reply;

  // Memories and their ports
  voice_t              voice_mem [VOICES];
  sound_t              sound_mem [MAX_SOUNDS];
  logic [31:0]         sample_mem [SAMPLE_FRAMES];
  voice_t              vm_q;
  voice_t              vm_wdata;
  logic                vm_we;
  logic [VAW-1:0]      vm_waddr;
  sound_t              sd_q;
  logic [31:0]         sm_q;
  logic [AW-1:0]       sm_raddr;

  // Tick pipeline
  logic                p1_valid;
  logic [VAW-1:0]      p1_idx;
  logic                p2_valid;
  logic [VAW-1:0]      p2_idx;
  voice_t              p2_voice;
  logic                p2_ended;
  logic                p2_drop;
  logic [LEN_W-1:0]    p2_pos_eff;
  logic [SUMW-1:0]     p2_addr_sum;
  logic                p3_valid;
  logic [31:0]         p3_gprod;
  logic                p4_valid;
  logic [VOL_W-1:0]    p4_gain;
  logic [SAMPLE_W-1:0] p4_left;
  logic [SAMPLE_W-1:0] p4_right;
  logic                p5_valid;
  logic signed [PW-1:0] p5_prod_l;
  logic signed [PW-1:0] p5_prod_r;
  logic signed [ACCW-1:0] acc_l;
  logic signed [ACCW-1:0] acc_r;

  // Command checks
  assign idx_last  = (idx == VAW'(VOICES - 1));
  assign snd_ok    = (32'(item_sound_select) < 32'(sound_count));
  assign stop_ok   = (32'(item_voice_select) < 32'(VOICES));
  assign add_bad   = (item_sound_length == '0) ||
                     (32'(item_sound_length) > 32'(SAMPLE_FRAMES)) ||
                     (32'(sound_count) >= 32'(MAX_SOUNDS));
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign pipe_busy = p1_valid || p2_valid || p3_valid || p4_valid || p5_valid;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the controller
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_cmd == CMD_TICK) begin
          state_next = ST_TICK;
        end else if (item_cmd == CMD_PLAY && snd_ok) begin
          state_next = ST_PLAY;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_PLAY: begin
        if (!active[idx] || idx_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_TICK: begin
        if (idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the command transaction
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_cmd           <= s_axis_tuser;
      item_frame_address <= s_axis_tdata[IN_FADDR_LO +: ADDR_W];
      item_sample_left   <= s_axis_tdata[IN_LEFT_LO +: SAMPLE_W];
      item_sample_right  <= s_axis_tdata[IN_RIGHT_LO +: SAMPLE_W];
      item_sound_start   <= s_axis_tdata[IN_START_LO +: ADDR_W];
      item_sound_length  <= s_axis_tdata[IN_LEN_LO +: LEN_W];
      item_sound_select  <= s_axis_tdata[IN_SEL_LO +: SEL_W];
      item_voice_volume  <= s_axis_tdata[IN_VOL_LO +: VOL_W];
      item_loop_enable   <= s_axis_tdata[IN_LOOP_BIT];
      item_voice_select  <= s_axis_tdata[IN_VSEL_LO +: VSEL_W];
    end
  end

  // Clamp and hold the master gain
  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain <= GAIN_UNITY;
    end else if (gain_wr_en) begin
      master_gain <= (gain_wr_data > GAIN_UNITY) ? GAIN_UNITY : gain_wr_data;
    end
  end

  // Count registered sounds
  always_ff @(posedge clk) begin
    if (rst) begin
      sound_count <= '0;
    end else if (state == ST_EXEC) begin
      if (item_cmd == CMD_CLEAR_ALL) begin
        sound_count <= '0;
      end else if (item_cmd == CMD_ADD_SOUND && !add_bad) begin
        sound_count <= sound_count + SCW'(1);
      end
    end
  end

  // Walk the voices for play and tick
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (state)
        ST_EXEC: begin
          idx <= '0;
        end
        ST_PLAY: begin
          if (active[idx] && !idx_last) begin
            idx <= idx + VAW'(1);
          end
        end
        ST_TICK: begin
          idx <= idx_last ? '0 : idx + VAW'(1);
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Track active voices
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (state == ST_EXEC && item_cmd == CMD_CLEAR_ALL) begin
        active <= '0;
      end
      if (state == ST_EXEC && item_cmd == CMD_STOP && stop_ok) begin
        active[VAW'(item_voice_select)] <= 1'b0;
      end
      if (state == ST_PLAY && !active[idx]) begin
        active[idx] <= 1'b1;
      end
      if (p2_valid && p2_drop) begin
        active[p2_idx] <= 1'b0;
      end
    end
  end

  // Select the voice memory write: a new voice on play, a position on tick
  always_comb begin
    vm_we          = 1'b0;
    vm_waddr       = p2_idx;
    vm_wdata       = p2_voice;
    vm_wdata.pos   = p2_pos_eff + LEN_W'(1);
    if (state == ST_PLAY && !active[idx]) begin
      vm_we            = 1'b1;
      vm_waddr         = idx;
      vm_wdata.snd     = SAW'(item_sound_select);
      vm_wdata.pos     = '0;
      vm_wdata.vol     = item_voice_volume;
      vm_wdata.loop_en = item_loop_enable;
    end else if (p2_valid && !p2_drop) begin
      vm_we = 1'b1;
    end
  end

  // Voice memory
  always_ff @(posedge clk) begin
    if (vm_we) begin
      voice_mem[vm_waddr] <= vm_wdata;
    end
    vm_q <= voice_mem[idx];
  end

  // Sound table
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && item_cmd == CMD_ADD_SOUND && !add_bad) begin
      sound_mem[SAW'(sound_count)] <= '{start: item_sound_start, length: item_sound_length};
    end
    sd_q <= sound_mem[vm_q.snd];
  end

  // Sample memory
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && item_cmd == CMD_WRITE_FRAME) begin
      sample_mem[AW'(item_frame_address)] <= {item_sample_right, item_sample_left};
    end
    sm_q <= sample_mem[sm_raddr];
  end

  // End-of-sound handling and sample address
  assign p2_ended    = (p2_voice.pos >= sd_q.length);
  assign p2_drop     = p2_ended && !p2_voice.loop_en;
  assign p2_pos_eff  = p2_ended ? '0 : p2_voice.pos;
  assign p2_addr_sum = SUMW'(sd_q.start) + SUMW'(p2_pos_eff);
  assign sm_raddr    = AW'(p2_addr_sum);

  // Advance the tick pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_TICK) && active[idx];
      p2_valid <= p1_valid;
      p3_valid <= p2_valid && !p2_drop;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;
    end
  end

  // Tick pipeline payload: gain, scale, accumulate
  always_ff @(posedge clk) begin
    p1_idx    <= idx;
    p2_idx    <= p1_idx;
    p2_voice  <= vm_q;
    p3_gprod  <= p2_voice.vol * master_gain;
    p4_gain   <= VOL_W'((33'(p3_gprod) + 33'(ROUND_HALF)) >> FRAC_BITS);
    p4_left   <= sm_q[SAMPLE_W-1:0];
    p4_right  <= sm_q[2*SAMPLE_W-1:SAMPLE_W];
    p5_prod_l <= $signed(p4_left) * $signed({1'b0, p4_gain});
    p5_prod_r <= $signed(p4_right) * $signed({1'b0, p4_gain});
    if (state == ST_EXEC) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (p5_valid) begin
      acc_l <= acc_l + ACCW'(p5_prod_l);
      acc_r <= acc_r + ACCW'(p5_prod_r);
    end
  end

  // Build the result of each command
  always_ff @(posedge clk) begin
    case (state)
      ST_EXEC: begin
        res_left   <= '0;
        res_right  <= '0;
        res_status <= 1'b0;
        res_reply  <= '0;
        case (item_cmd)
          CMD_TICK, CMD_WRITE_FRAME, CMD_STOP, CMD_CLEAR_ALL: begin
            res_status <= 1'b0;
          end
          CMD_ADD_SOUND: begin
            if (add_bad) begin
              res_status <= 1'b1;
            end else begin
              res_reply <= REPLY_W'(sound_count);
            end
          end
          CMD_PLAY: begin
            res_status <= !snd_ok;
          end
          default: begin
            res_status <= 1'b1;
          end
        endcase
      end
      ST_PLAY: begin
        if (!active[idx]) begin
          res_reply <= REPLY_W'(idx);
        end else if (idx_last) begin
          res_status <= 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          res_left  <= round_clip(acc_l);
          res_right <= round_clip(acc_r);
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      m_axis_tdata <= {1'b0, res_reply, res_status, res_right, res_left};
    end
  end

`ifndef NO_ASSERTIONS
  // The voice pipeline is empty whenever a result is handed over
  a_drained_at_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT) |-> !pipe_busy)
    else $error("tick pipeline still busy at result");

  // A new result appears only from the result state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_RESULT))
    else $error("result raised outside result state");

  // A rejected command never reports an index
  a_reject_no_reply: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[OUT_STATUS_BIT]) |->
    (m_axis_tdata[OUT_REPLY_LO +: REPLY_W] == '0))
    else $error("rejected result carries a reply index");

  // Voices enter the pipeline only during a tick walk
  a_issue_in_tick: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> $past(state == ST_TICK))
    else $error("voice issued outside a tick");

  // The sound count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sound_count) <= 32'(MAX_SOUNDS))
    else $error("sound count beyond table size");
`endif

endmodule
